// File: hdl/suk_pkg.sv
// Shared types, constants and codes for the sorted unique key table.
// No dependencies; imported by every module of the block.
package suk_pkg;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 5;
  localparam int unsigned CapacityDef = 16;

  typedef logic signed [KeyW-1:0] key_t;

  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 2'd1;
  localparam logic [ModeW-1:0] MODE_SEARCH = 2'd2;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd3;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_MISS = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    key_t             key;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } suk_ctrl_t;

endpackage

// File: hdl/suk_cell.sv
// One slot of the key chain: holds a key and its compare flags.
// Depends on suk_pkg.
module suk_cell import suk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  suk_ctrl_t ctrl_i,
  input  key_t      search_key_i,
  input  logic      occupied_i,
  input  key_t      left_key_i,
  input  logic      left_lt_i,
  input  key_t      right_key_i,
  output key_t      key_o,
  output logic      lt_o,
  output logic      eq_o
);

  key_t key_q, key_d;
  logic lt_q, lt_d;
  logic eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      lt_d = occupied_i && (key_q < search_key_i);
      eq_d = occupied_i && (key_q == search_key_i);
    end
  end

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en && !lt_q) begin
      key_d = left_lt_i ? search_key_i : left_key_i;
    end else if (ctrl_i.del_en && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// File: hdl/suk_chain.sv
// Row of key cells linked to their neighbours for shifting on insert and delete.
// Depends on suk_pkg and suk_cell.
module suk_chain import suk_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  suk_ctrl_t           ctrl_i,
  input  key_t                search_key_i,
  input  logic [CntW-1:0]     count_i,
  output logic [Capacity-1:0] lt_o,
  output logic [Capacity-1:0] eq_o
);

  key_t keys [Capacity];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    key_t left_key;
    key_t right_key;
    logic left_lt;

    if (i == 0) begin : g_first
      assign left_key = search_key_i;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_key = keys[i-1];
      assign left_lt  = lt_o[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_notlast
      assign right_key = keys[i+1];
    end

    suk_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .search_key_i (search_key_i),
      .occupied_i   (CntW'(i) < count_i),
      .left_key_i   (left_key),
      .left_lt_i    (left_lt),
      .right_key_i  (right_key),
      .key_o        (keys[i]),
      .lt_o         (lt_o[i]),
      .eq_o         (eq_o[i])
    );
  end

endmodule

// File: hdl/sorted_unique_key_table.sv
// Top level of the sorted unique key table: control sequencer and result register.
// Depends on suk_pkg and suk_chain.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (mode, key)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (status, entry_count)
//
// A transaction passes through accept, a compare state in which every cell registers its
// compare flags, and an update state that shifts the chain and loads the result.
// The update waits while a previous result is still stalled in the output register.
// Reset empties the table at once; the key cells need no clearing.
module sorted_unique_key_table import suk_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  in_item_t            item_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [Capacity-1:0] lt;
  logic [Capacity-1:0] eq;
  suk_ctrl_t           ctrl;
  logic                accept;
  logic                upd_go;
  logic                present;
  logic                full;

  assign accept  = in_valid_i && !in_stall_o;
  assign upd_go  = (state_q == S_UPD) && !(out_valid_q && out_stall_i);
  assign present = |eq;
  assign full    = (cnt_q == CntW'(Capacity));

  always_comb begin
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.ins_en = upd_go && (item_q.mode == MODE_INSERT) && !present && !full;
    ctrl.del_en = upd_go && (item_q.mode == MODE_DELETE) && present;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (upd_go) begin
      out_d.status = STATUS_OK;
      case (item_q.mode)
        MODE_INSERT: begin
          if (present) begin
            out_d.status = STATUS_MISS;
          end else if (full) begin
            out_d.status = STATUS_FULL;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        MODE_DELETE: begin
          if (!present) begin
            out_d.status = STATUS_MISS;
          end else begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
        MODE_SEARCH: out_d.status = present ? STATUS_OK : STATUS_MISS;
        default:     cnt_d = '0;
      endcase
      out_d.entry_count = CountW'(cnt_d);
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  suk_chain #(
    .Capacity (Capacity),
    .CntW     (CntW)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .search_key_i (item_q.key),
    .count_i      (cnt_q),
    .lt_o         (lt),
    .eq_o         (eq)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(eq))
    else $error("key matched in more than one cell");

  a_lt_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ((lt & (lt + Capacity'(1))) == '0))
    else $error("less-than flags not a prefix of the chain");

  a_count_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> $past(state_q == S_UPD))
    else $error("entry count changed outside update cycle");

  a_result_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPD))
    else $error("result raised outside update cycle");

endmodule
